@@ rtl/lufs_pkg.sv @@
// shared types and codes of the lu factor and solve engine
package lufs_pkg;

    localparam int DEF_MAX_ORDER = 64;
    localparam int DEF_FRAC_BITS = 16;

    localparam int ORDER_W  = 7;
    localparam int THRESH_W = 16;
    localparam int CFG_W    = 16;

    localparam logic [2:0] OP_WR_MATRIX = 3'd0;
    localparam logic [2:0] OP_WR_RHS    = 3'd1;
    localparam logic [2:0] OP_FACTOR    = 3'd2;
    localparam logic [2:0] OP_SOLVE     = 3'd3;
    localparam logic [2:0] OP_READ_SOL  = 3'd4;

    localparam logic CFG_ORDER  = 1'b0;
    localparam logic CFG_THRESH = 1'b1;

    typedef struct packed {
        logic [2:0]         operation;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] entry_value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               zero_pivot;
    } t_rsp;

endpackage

@@ rtl/lufs_div.sv @@
// bit-serial fixed-point divider, quotient truncated toward zero and saturated
module lufs_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot
);
    localparam int NB = 32 + FRAC_BITS;
    localparam int CW = $clog2(NB + 1);

    logic          r_busy, r_done, r_neg;
    logic [CW-1:0] r_cnt;
    logic [31:0]   r_rem, r_dmag;
    logic [NB-1:0] r_q;
    logic [32:0]   num_abs, den_abs, trial;
    logic          ge;

    assign num_abs = i_num[31] ? -{i_num[31], i_num} : {i_num[31], i_num};
    assign den_abs = i_den[31] ? -{i_den[31], i_den} : {i_den[31], i_den};
    assign trial   = {r_rem, r_q[NB-1]};
    assign ge      = trial >= {1'b0, r_dmag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= {num_abs[31:0], {FRAC_BITS{1'b0}}};
            r_rem  <= '0;
            r_dmag <= den_abs[31:0];
            r_neg  <= i_num[31] ^ i_den[31];
        end else if (r_busy) begin
            r_rem <= ge ? 32'(trial - {1'b0, r_dmag}) : trial[31:0];
            r_q   <= {r_q[NB-2:0], ge};
        end
    end

    always_comb begin
        if (!r_neg) begin
            o_quot = (r_q > NB'(32'h7fffffff)) ? 32'sh7fffffff : signed'(r_q[31:0]);
        end else begin
            o_quot = (r_q > NB'(33'h080000000)) ? 32'sh80000000 : signed'(-r_q[31:0]);
        end
    end

    assign o_done = r_done;
endmodule

@@ rtl/lu_factor_solve.sv @@
// dense lu factor and solve engine over q16.16 fixed point
//
// requests enter on start/i_req, accepted at a clock edge with start high and
// busy low. every request gives one response on o_rsp, marked by o_strobe for
// exactly one cycle; the receiver cannot stall it.
// matrix write, rhs write, solution read and unknown codes: response in the
// cycle after the request, one request per cycle, busy stays low.
// factor: busy high while each lu entry is computed in turn (two memory read
// ports feed one multiplier and one accumulator); an entry waits on the
// bit-serial divider when it needs a division. solve: forward then back
// substitution over the same datapath. the response of factor and solve comes
// in the cycle busy falls. configuration writes (order, pivot threshold) take
// effect at once and are to be made only while idle: the user keeps to this,
// the block itself has no check for it. reset clears the pivot flag and the
// control state and sets order 64 and threshold 1; the datapath registers and
// the matrix, rhs and solution memories are not cleared.
module lu_factor_solve #(
    parameter int MAX_ORDER = lufs_pkg::DEF_MAX_ORDER,
    parameter int FRAC_BITS = lufs_pkg::DEF_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  lufs_pkg::t_req           i_req,
    output logic                     o_strobe,
    output lufs_pkg::t_rsp           o_rsp,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [lufs_pkg::CFG_W-1:0] i_cfg_data
);
    import lufs_pkg::*;

    localparam int AW = $clog2(MAX_ORDER);
    localparam int NW = $clog2(MAX_ORDER + 1);
    localparam int LD = 1 << (2 * AW);
    localparam logic signed [63:0] HALF = 64'sd1 << (FRAC_BITS - 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_CAPT  = 7'b0000100,
        S_TERMS = 7'b0001000,
        S_DIFF  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_WB    = 7'b1000000
    } t_state;

    typedef enum logic [3:0] {
        PH_U    = 4'b0001,
        PH_L    = 4'b0010,
        PH_FWD  = 4'b0100,
        PH_BACK = 4'b1000
    } t_phase;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh000000007fffffff) return 32'sh7fffffff;
        if (v < -64'sh0000000080000000) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [2*AW-1:0] lu_addr(input logic [NW-1:0] r, input logic [NW-1:0] c);
        return {r[AW-1:0], c[AW-1:0]};
    endfunction

    logic signed [31:0] lu_mem  [LD];
    logic signed [31:0] rhs_mem [1 << AW];
    logic signed [31:0] sol_mem [1 << AW];

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [NW-1:0] r_k, n_k, r_i, n_i, r_s, n_s, r_n, n_n;
    logic r_v1, n_v1, r_v2, n_v2;
    logic r_flag, n_flag, r_resp, n_resp, r_resp_rd, n_resp_rd, r_tiny, n_tiny;
    logic [ORDER_W-1:0]  r_order;
    logic [THRESH_W-1:0] r_thr;
    logic signed [31:0] r_tgt, n_tgt, r_piv, n_piv, r_res, n_res;
    logic signed [63:0] r_acc, n_acc, r_prod;
    logic signed [31:0] r_lu_a, r_lu_b, r_sol_rd, r_rhs_rd;

    logic accept, row_ok, col_ok, issue, div_start, div_done;
    logic [NW-1:0] n_act, s_begin, s_end;
    logic [2*AW-1:0] addr_a, addr_b, lu_waddr;
    logic [AW-1:0] sol_raddr, rhs_raddr;
    logic lu_we, sol_we, rhs_we;
    logic signed [31:0] lu_wdata, diff, div_quot, op_b;
    logic signed [63:0] rnd;

    function automatic logic near_zero(input logic signed [31:0] u, input logic [THRESH_W-1:0] t);
        logic [32:0] m;
        m = u[31] ? -{u[31], u} : {u[31], u};
        return (m == '0) || (m < {17'b0, t});
    endfunction

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign row_ok = 32'(i_req.row) < MAX_ORDER;
    assign col_ok = 32'(i_req.col) < MAX_ORDER;

    always_comb begin
        if (r_order == '0) begin
            n_act = NW'(1);
        end else if (32'(r_order) > MAX_ORDER) begin
            n_act = NW'(MAX_ORDER);
        end else begin
            n_act = NW'(r_order);
        end
    end

    // term range of the dot product for the entry in work
    assign s_begin = (r_phase == PH_BACK) ? r_i + 1'b1 : '0;
    assign s_end   = (r_phase == PH_U || r_phase == PH_L) ? r_k :
                     (r_phase == PH_FWD) ? r_i : r_n;
    assign issue   = (r_state == S_TERMS) && (r_s < s_end);

    assign op_b = (r_phase == PH_U || r_phase == PH_L) ? r_lu_b : r_sol_rd;
    assign rnd  = (r_prod + HALF) >>> FRAC_BITS;
    assign diff = sat32(64'(r_tgt) - r_acc);

    // read address selection
    always_comb begin
        addr_a    = lu_addr(r_i, r_s);
        addr_b    = (r_phase == PH_U) ? lu_addr(r_s, r_i) : lu_addr(r_s, r_k);
        sol_raddr = r_s[AW-1:0];
        rhs_raddr = r_i[AW-1:0];
        case (r_state)
            S_IDLE: begin
                sol_raddr = AW'(i_req.row);
            end
            S_LOAD: begin
                sol_raddr = r_i[AW-1:0];
                case (r_phase)
                    PH_U:    addr_a = lu_addr(r_k, r_i);
                    PH_L:    addr_a = lu_addr(r_i, r_k);
                    default: addr_a = lu_addr(r_i, r_i);
                endcase
            end
            S_TERMS: begin
                if (r_phase == PH_U) begin
                    addr_a = lu_addr(r_k, r_s);
                end
            end
            default: ;
        endcase
    end

    // write ports
    always_comb begin
        lu_we    = 1'b0;
        lu_waddr = (r_phase == PH_U) ? lu_addr(r_k, r_i) : lu_addr(r_i, r_k);
        lu_wdata = r_res;
        if (accept && i_req.operation == OP_WR_MATRIX && row_ok && col_ok) begin
            lu_we    = 1'b1;
            lu_waddr = {AW'(i_req.row), AW'(i_req.col)};
            lu_wdata = i_req.entry_value;
        end else if (r_state == S_WB && (r_phase == PH_U || r_phase == PH_L)) begin
            lu_we = 1'b1;
        end
    end
    assign sol_we = (r_state == S_WB) && (r_phase == PH_FWD || r_phase == PH_BACK);
    assign rhs_we = accept && i_req.operation == OP_WR_RHS && row_ok;

    always_ff @(posedge i_clk) begin
        if (lu_we) begin
            lu_mem[lu_waddr] <= lu_wdata;
        end
        r_lu_a <= lu_mem[addr_a];
        r_lu_b <= lu_mem[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (sol_we) begin
            sol_mem[r_i[AW-1:0]] <= r_res;
        end
        r_sol_rd <= sol_mem[sol_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (rhs_we) begin
            rhs_mem[AW'(i_req.row)] <= i_req.entry_value;
        end
        r_rhs_rd <= rhs_mem[rhs_raddr];
    end

    lufs_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (diff),
        .i_den  (r_piv),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    // sequencer; entries are handled one at a time, so a write-back always
    // lands before the next entry's reads are issued
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_k       = r_k;
        n_i       = r_i;
        n_s       = r_s;
        n_n       = r_n;
        n_v1      = issue;
        n_v2      = r_v1;
        n_flag    = r_flag;
        n_resp    = 1'b0;
        n_resp_rd = 1'b0;
        n_tiny    = r_tiny;
        n_tgt     = r_tgt;
        n_piv     = r_piv;
        n_res     = r_res;
        n_acc     = r_v2 ? r_acc + rnd : r_acc;
        div_start = 1'b0;
        if (issue) begin
            n_s = r_s + 1'b1;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_n = n_act;
                    n_k = '0;
                    n_i = '0;
                    if (i_req.operation == OP_FACTOR) begin
                        n_flag  = 1'b0;
                        n_phase = PH_U;
                        n_state = S_LOAD;
                    end else if (i_req.operation == OP_SOLVE) begin
                        n_flag  = 1'b0;
                        n_phase = PH_FWD;
                        n_state = S_LOAD;
                    end else begin
                        n_resp    = 1'b1;
                        n_resp_rd = (i_req.operation == OP_READ_SOL) && row_ok;
                    end
                end
            end
            S_LOAD: begin
                n_state = S_CAPT;
            end
            S_CAPT: begin
                case (r_phase)
                    PH_FWD:  n_tgt = r_rhs_rd;
                    PH_BACK: n_tgt = r_sol_rd;
                    default: n_tgt = r_lu_a;
                endcase
                if (r_phase == PH_BACK) begin
                    n_piv = r_lu_a;
                end
                n_s     = s_begin;
                n_acc   = '0;
                n_v1    = 1'b0;
                n_v2    = 1'b0;
                n_state = S_TERMS;
            end
            S_TERMS: begin
                if (!issue && !r_v1 && !r_v2) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                n_res   = diff;
                n_state = S_WB;
                case (r_phase)
                    PH_U: begin
                        if (r_i == r_k) begin
                            n_piv  = diff;
                            n_tiny = near_zero(diff, r_thr);
                            if (near_zero(diff, r_thr)) begin
                                n_flag = 1'b1;
                            end
                        end
                    end
                    PH_L: begin
                        if (r_tiny) begin
                            n_res = '0;
                        end else begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                    end
                    PH_BACK: begin
                        if (near_zero(r_piv, r_thr)) begin
                            n_res  = '0;
                            n_flag = 1'b1;
                        end else begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                    end
                    default: ;
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    n_res   = div_quot;
                    n_state = S_WB;
                end
            end
            S_WB: begin
                n_state = S_LOAD;
                case (r_phase)
                    PH_U: begin
                        if (r_i + 1'b1 < r_n) begin
                            n_i = r_i + 1'b1;
                        end else if (r_k + 1'b1 < r_n) begin
                            n_phase = PH_L;
                            n_i     = r_k + 1'b1;
                        end else begin
                            n_state = S_IDLE;
                            n_resp  = 1'b1;
                        end
                    end
                    PH_L: begin
                        if (r_i + 1'b1 < r_n) begin
                            n_i = r_i + 1'b1;
                        end else begin
                            n_phase = PH_U;
                            n_k     = r_k + 1'b1;
                            n_i     = r_k + 1'b1;
                        end
                    end
                    PH_FWD: begin
                        if (r_i + 1'b1 < r_n) begin
                            n_i = r_i + 1'b1;
                        end else begin
                            n_phase = PH_BACK;
                            n_i     = r_n - 1'b1;
                        end
                    end
                    default: begin
                        if (r_i == '0) begin
                            n_state = S_IDLE;
                            n_resp  = 1'b1;
                        end else begin
                            n_i = r_i - 1'b1;
                        end
                    end
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_U;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_flag    <= 1'b0;
            r_resp    <= 1'b0;
            r_resp_rd <= 1'b0;
            r_order   <= ORDER_W'(64);
            r_thr     <= THRESH_W'(1);
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_v1      <= n_v1;
            r_v2      <= n_v2;
            r_flag    <= n_flag;
            r_resp    <= n_resp;
            r_resp_rd <= n_resp_rd;
            if (i_cfg_we && i_cfg_idx == CFG_ORDER) begin
                r_order <= i_cfg_data[ORDER_W-1:0];
            end
            if (i_cfg_we && i_cfg_idx == CFG_THRESH) begin
                r_thr <= i_cfg_data[THRESH_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_i    <= n_i;
        r_s    <= n_s;
        r_n    <= n_n;
        r_tiny <= n_tiny;
        r_tgt  <= n_tgt;
        r_piv  <= n_piv;
        r_res  <= n_res;
        r_acc  <= n_acc;
        r_prod <= r_lu_a * op_b;
    end

    assign o_strobe         = r_resp;
    assign o_rsp.read_value = r_resp_rd ? r_sol_rd : 32'sd0;
    assign o_rsp.zero_pivot = r_flag;

`ifndef NO_ASSERTIONS
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("response strobed while busy");

    a_quick_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.operation != OP_FACTOR && i_req.operation != OP_SOLVE)
        |=> o_strobe)
        else $error("missing response one cycle after a quick request");

    a_long_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.operation == OP_FACTOR || i_req.operation == OP_SOLVE))
        |=> (busy && !o_strobe && !o_rsp.zero_pivot))
        else $error("factor or solve did not start with a cleared flag");

    a_div_in_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");
`endif
endmodule
